/* hw/rtl/dss_pkg.sv */
package dss_pkg;

  localparam int unsigned DEF_CAPACITY = 64;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned ACTION_W     = 2;
  localparam int unsigned COUNT_OUT_W  = 7;
  localparam int unsigned OUT_DATA_W   = 16;

  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_cmd_t;

endpackage

/* hw/rtl/dss_cell.sv */
module dss_cell #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned CntW = 7
) (
  input  logic                         clk_i,
  input  dss_pkg::cell_cmd_t           cmd_i,
  input  logic [dss_pkg::VALUE_W-1:0]  value_i,
  input  logic [CntW-1:0]              count_i,
  input  logic [dss_pkg::VALUE_W-1:0]  nbr_data_i,
  input  logic                         hit_i,
  output logic [dss_pkg::VALUE_W-1:0]  data_o,
  output logic                         hit_o
);

  logic [dss_pkg::VALUE_W-1:0] data_q, data_d;
  logic                        active;
  logic                        match;

  assign active = CntW'(Idx) < count_i;
  assign match  = active && (data_q == value_i);
  assign hit_o  = hit_i | match;
  assign data_o = data_q;

  always_comb begin
    data_d = data_q;
    if (cmd_i.rem && hit_o) begin
      data_d = nbr_data_i;
    end else if (cmd_i.ins && (count_i == CntW'(Idx))) begin
      data_d = value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

/* hw/rtl/dedup_set_store.sv */
// Set of up to CAPACITY distinct 32-bit values kept in insertion order.
// Each input beat (tuser = action, tdata = value) yields one output beat
// reporting prior membership, a full-drop status and the new entry count.
// Every entry sits in its own cell; all cells compare in parallel and a
// remove shifts later cells down by one, so one beat is handled per clock
// while the output is taken; the input is ready whenever the output register
// is empty or being taken, and each result is registered as its beat is accepted.
// Entries are qualified by the count, so no clearing pass runs after reset.
module dedup_set_store #(
  parameter int unsigned CAPACITY = dss_pkg::DEF_CAPACITY
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [dss_pkg::VALUE_W-1:0]    s_axis_tdata,   // [31:0] value
  input  logic [dss_pkg::ACTION_W-1:0]   s_axis_tuser,   // [1:0] action
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [dss_pkg::OUT_DATA_W-1:0] m_axis_tdata    // [0] was_member, [1] status,
                                                         // [8:2] count, [15:9] zero
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0]             cnt_q, cnt_d;
  logic                        out_valid_q;
  logic [dss_pkg::OUT_DATA_W-1:0] out_data_q;

  logic                        accept;
  logic                        member;
  logic                        is_ins, is_rem;
  logic                        room;
  dss_pkg::cell_cmd_t          cmd;
  logic                        drop;
  logic [CntW+dss_pkg::COUNT_OUT_W-1:0] cnt_ext;

  logic [dss_pkg::VALUE_W-1:0] cell_data [CAPACITY];
  logic [CAPACITY:0]           hit_chain;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !out_valid_q || m_axis_tready;

  assign is_ins = s_axis_tuser == dss_pkg::ACT_INSERT;
  assign is_rem = s_axis_tuser == dss_pkg::ACT_REMOVE;
  assign room   = cnt_q < CntW'(CAPACITY);
  assign member = hit_chain[CAPACITY];

  assign cmd.ins = accept && is_ins && !member && room;
  assign cmd.rem = accept && is_rem && member;
  assign drop    = is_ins && !member && !room;

  assign hit_chain[0] = 1'b0;

  for (genvar g = 0; g < CAPACITY; g++) begin : gen_cell
    logic [dss_pkg::VALUE_W-1:0] nbr;
    if (g == CAPACITY - 1) begin : gen_last
      assign nbr = s_axis_tdata;
    end else begin : gen_mid
      assign nbr = cell_data[g+1];
    end
    dss_cell #(
      .Idx  (g),
      .CntW (CntW)
    ) u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .value_i    (s_axis_tdata),
      .count_i    (cnt_q),
      .nbr_data_i (nbr),
      .hit_i      (hit_chain[g]),
      .data_o     (cell_data[g]),
      .hit_o      (hit_chain[g+1])
    );
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd.ins) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (cmd.rem) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  assign cnt_ext = {{dss_pkg::COUNT_OUT_W{1'b0}}, cnt_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= {7'b0, cnt_ext[dss_pkg::COUNT_OUT_W-1:0], drop, member};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

/* tb/tb_top.sv */
module tb_top;

  import dss_pkg::*;

  localparam int unsigned          CAPACITY   = DEF_CAPACITY;
  localparam logic [ACTION_W-1:0]  ACT_SPARE  = 2'd3;
  localparam int unsigned          POOL_SIZE  = 90;
  localparam int unsigned          N_RANDOM   = 600;

  typedef struct packed {
    logic [COUNT_OUT_W-1:0] count;
    logic                   status;
    logic                   was_member;
  } set_result_t;

  typedef struct {
    logic [ACTION_W-1:0] act;
    logic [VALUE_W-1:0]  val;
    bit                  typed;
    set_result_t         res;
  } dir_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [VALUE_W-1:0]     s_axis_tdata;
  logic [ACTION_W-1:0]    s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;

  logic                   row_typed;
  set_result_t            row_res;
  bit                     calm;

  logic [VALUE_W-1:0]     set_model[$];
  set_result_t            pending_results[$];
  logic [VALUE_W-1:0]     value_pool[POOL_SIZE];
  int                     n_errors;

  dir_row_t dir_rows [20] = '{
    '{ACT_QUERY,  32'h0000_0000, 1'b1, {7'd0, 1'b0, 1'b0}},
    '{ACT_REMOVE, 32'h0000_0000, 1'b1, {7'd0, 1'b0, 1'b0}},
    '{ACT_INSERT, 32'h8000_0000, 1'b1, {7'd1, 1'b0, 1'b0}},
    '{ACT_INSERT, 32'h7fff_ffff, 1'b1, {7'd2, 1'b0, 1'b0}},
    '{ACT_INSERT, 32'h7fff_ffff, 1'b1, {7'd2, 1'b0, 1'b1}},
    '{ACT_INSERT, 32'h0000_0000, 1'b1, {7'd3, 1'b0, 1'b0}},
    '{ACT_INSERT, 32'hffff_ffff, 1'b1, {7'd4, 1'b0, 1'b0}},
    '{ACT_QUERY,  32'h8000_0000, 1'b1, {7'd4, 1'b0, 1'b1}},
    '{ACT_SPARE,  32'hffff_ffff, 1'b1, {7'd4, 1'b0, 1'b1}},
    '{ACT_SPARE,  32'h0000_0005, 1'b1, {7'd4, 1'b0, 1'b0}},
    '{ACT_REMOVE, 32'h8000_0000, 1'b1, {7'd3, 1'b0, 1'b1}},
    '{ACT_QUERY,  32'h7fff_ffff, 1'b0, '0},
    '{ACT_REMOVE, 32'hffff_ffff, 1'b0, '0},
    '{ACT_REMOVE, 32'hffff_ffff, 1'b1, {7'd2, 1'b0, 1'b0}},
    '{ACT_INSERT, 32'h8000_0000, 1'b0, '0},
    '{ACT_QUERY,  32'h5555_5555, 1'b0, '0},
    '{ACT_INSERT, 32'haaaa_aaaa, 1'b0, '0},
    '{ACT_REMOVE, 32'h7fff_ffff, 1'b0, '0},
    '{ACT_INSERT, 32'h0000_0001, 1'b0, '0},
    '{ACT_QUERY,  32'h0000_0000, 1'b0, '0}
  };

  dedup_set_store #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic set_result_t apply_set_op(logic [ACTION_W-1:0] act,
                                               logic [VALUE_W-1:0] val);
    set_result_t r;
    int          pos;
    pos = -1;
    foreach (set_model[i]) begin
      if (pos < 0 && set_model[i] == val) begin
        pos = i;
      end
    end
    r.was_member = (pos >= 0);
    r.status     = 1'b0;
    if (act == ACT_INSERT && pos < 0) begin
      if (set_model.size() < CAPACITY) begin
        set_model.push_back(val);
      end else begin
        r.status = 1'b1;
      end
    end else if (act == ACT_REMOVE && pos >= 0) begin
      set_model.delete(pos);
    end
    r.count = COUNT_OUT_W'(set_model.size());
    return r;
  endfunction

  always @(negedge clk_i) begin
    m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 26);
  end

  always @(posedge clk_i) begin
    set_result_t got;
    set_result_t want;
    set_result_t pred;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = set_result_t'(m_axis_tdata[COUNT_OUT_W+1:0]);
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected beat, got %h", $time, m_axis_tdata);
          n_errors++;
        end else begin
          want = pending_results.pop_front();
          if (got.was_member !== want.was_member) begin
            $display("%0t: was_member expected %0b actual %0b",
                     $time, want.was_member, got.was_member);
            n_errors++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0b actual %0b",
                     $time, want.status, got.status);
            n_errors++;
          end
          if (got.count !== want.count) begin
            $display("%0t: count expected %0d actual %0d",
                     $time, want.count, got.count);
            n_errors++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pred = apply_set_op(s_axis_tuser, s_axis_tdata);
        pending_results.push_back(row_typed ? row_res : pred);
      end
    end
  end

  task automatic send_beat(logic [ACTION_W-1:0] act, logic [VALUE_W-1:0] val,
                           logic typed, set_result_t res);
    while (!calm && $urandom_range(99) < 26) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= val;
    row_typed     <= typed;
    row_res       <= res;
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
  endtask

  function automatic logic [ACTION_W-1:0] pick_action(int unsigned blk);
    int unsigned r;
    r = $urandom_range(99);
    case (blk % 3)
      0: begin
        if (r < 70) return ACT_INSERT;
        if (r < 82) return ACT_REMOVE;
      end
      1: begin
        if (r < 20) return ACT_INSERT;
        if (r < 80) return ACT_REMOVE;
      end
      default: begin
        if (r < 40) return ACT_INSERT;
        if (r < 70) return ACT_REMOVE;
      end
    endcase
    return (r < 95) ? ACT_QUERY : ACT_SPARE;
  endfunction

  initial begin
    logic [ACTION_W-1:0] act;
    logic [VALUE_W-1:0]  val;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_QUERY;
    m_axis_tready = 1'b0;
    row_typed     = 1'b0;
    row_res       = '0;
    calm          = 1'b0;
    n_errors      = 0;
    foreach (value_pool[i]) begin
      value_pool[i] = $urandom();
    end
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].act, dir_rows[i].val, dir_rows[i].typed, dir_rows[i].res);
    end

    for (int unsigned k = 0; k < N_RANDOM; k++) begin
      calm = (k >= 300 && k < 450);
      act  = pick_action(k < 150 ? 0 : k / 75);
      if ($urandom_range(99) < 85) begin
        val = value_pool[$urandom_range(POOL_SIZE - 1)];
      end else begin
        val = $urandom();
      end
      send_beat(act, val, 1'b0, '0);
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (10) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
